>>> rtl/core/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg - shared types and constants of the 3x3 fixed-mask filter
// Widths of the stream fields, configuration register codes, the queue
// entry passed from the front to the back, and the mask coefficient table.
// ----------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MIN_WIDTH   = 3;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_HEIGHT  = 2;

	localparam int PIX_W       = 8;
	localparam int RES_W       = 13;
	localparam int COEF_W      = 4;
	localparam int MASK_W      = 3;
	localparam int NUM_MASKS   = 8;
	localparam int COL_W       = 10;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int ROW_W       = 13;
	localparam int QCNT_W      = 23;
	localparam int DIV_CNT_W   = 5;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCOUNT_W    = 3;

	// line memory holds both rows above at one address: {two above, above}
	localparam int LINE_W      = 2 * PIX_W;
	localparam int CLR_W       = COL_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MASK_SELECT  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_index_t;

	// classified item from the front
	typedef struct packed {
		logic [COL_W-1:0] col;       // line memory address
		logic [PIX_W-1:0] pix;
		logic             tap0_en;   // row two above lies inside the frame
		logic             tap1_en;   // row above lies inside the frame
		logic             tap2_en;   // current pixel is real and inside the frame
		logic             emit;      // item completes a result
		logic             first_col; // result sits in column 0
		logic             eor;       // result is last of its row
		logic             eof;       // result is last of the frame
	} c3f_item_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	// rows x columns per mask; codes five to seven give all-zero masks
	localparam coef_t KERNELS [NUM_MASKS][3][3] = '{
		'{'{ 4'sd0, -4'sd1,  4'sd0}, '{-4'sd1,  4'sd5, -4'sd1}, '{ 4'sd0, -4'sd1,  4'sd0}},
		'{'{ 4'sd0,  4'sd0,  4'sd0}, '{-4'sd1,  4'sd1,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}},
		'{'{ 4'sd0,  4'sd1,  4'sd0}, '{ 4'sd1,  4'sd4,  4'sd1}, '{ 4'sd0,  4'sd1,  4'sd0}},
		'{'{-4'sd1,  4'sd0,  4'sd1}, '{-4'sd2,  4'sd0,  4'sd2}, '{-4'sd1,  4'sd0,  4'sd1}},
		'{'{ 4'sd1, -4'sd2,  4'sd1}, '{-4'sd2,  4'sd5,  4'sd2}, '{ 4'sd1, -4'sd2,  4'sd1}},
		'{'{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}},
		'{'{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}},
		'{'{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}, '{ 4'sd0,  4'sd0,  4'sd0}}
	};

endpackage

`default_nettype wire

>>> rtl/core/conv3x3_fixed_mask_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_fixed_mask_filter - 3x3 fixed-mask convolution, zero padding
// Raster pixel stream in, one signed 3x3 sum per pixel out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock when the output
// is not stalled; the line memory has one read and one write port, one
// access of each per item. An item that completes a result passes the
// queue, the read stage, the window, the row sums and the output register;
// each result lags its pixel by one row plus one pixel in the stream, so
// after a frame send image_width+1 items with tuser set to flush it.
// s_tready is low while the line memory is cleared after reset, while
// cfg_valid is high, and after any register write while the result column
// is rebuilt for the new width, one bit of the result count per cycle.
// Registers: 0 mask select, 1 width, 2 height.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_fixed_mask_filter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [c3f_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [c3f_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [c3f_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] pixel_value
	input  wire logic                               s_tuser,   // is_pad
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [c3f_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [12:0] filtered_value
	output logic                                    m_tuser,   // end_of_row
	output logic                                    m_tlast    // end_of_frame
);

	import c3f_pkg::*;

	logic              clear_busy;
	logic              q_full;
	logic              push;
	c3f_item_t         push_item;
	logic              pop;
	c3f_item_t         head_item;
	logic              not_empty;
	logic [MASK_W-1:0] mask;

	c3f_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item),
		.mask       (mask)
	);

	c3f_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (not_empty),
		.full      (q_full)
	);

	c3f_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_item  (head_item),
		.not_empty  (not_empty),
		.pop        (pop),
		.mask       (mask),
		.clear_busy (clear_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

>>> rtl/core/c3f_ram.sv
// ----------------------------------------------------------------------------
// c3f_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rd_data_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front - configuration registers and stream position tracking
// Accepts pixels, tracks the input and result positions in the frame and
// classifies each item for the back. After a register write the result
// column is rebuilt from the result count by a bit-serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [c3f_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [c3f_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [c3f_pkg::TDATA_IN_W-1:0]   s_tdata,
	input  wire logic                             s_tuser,
	input  wire logic                             clear_busy,
	input  wire logic                             q_full,
	output logic                                  push,
	output c3f_pkg::c3f_item_t                    push_item,
	output logic      [c3f_pkg::MASK_W-1:0]       mask
);

	import c3f_pkg::*;

	logic [MASK_W-1:0]    mask_q;
	logic [WIDTH_W-1:0]   w_q;
	logic [HEIGHT_W-1:0]  h_q;
	logic [QCNT_W-1:0]    hw_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [QCNT_W-1:0]    out_count_q;
	logic [COL_W-1:0]     out_col_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 cfg_wr;
	logic                 busy;
	logic                 wrap_in;
	logic [COL_W-1:0]     col0;
	logic [ROW_W-1:0]     row0;
	logic [ROW_W:0]       r_ext;
	logic [ROW_W:0]       h_ext;
	logic                 emit;
	logic [WIDTH_W-1:0]   col_inc;
	logic                 col_wrap;
	logic [WIDTH_W-1:0]   oc_inc;
	logic [COL_W-1:0]     oc_next;
	logic                 first_col;
	logic                 eor;
	logic                 eof;
	logic [QCNT_W:0]      hw_full;
	logic [DIV_CNT_W-1:0] div_idx;
	logic [WIDTH_W-1:0]   div_shift;
	logic [COL_W-1:0]     div_rem;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
		logic [WIDTH_W-1:0] r;
		r = v;
		if (v < WIDTH_W'(MIN_WIDTH)) begin
			r = WIDTH_W'(MIN_WIDTH);
		end else if (v > WIDTH_W'(MAX_WIDTH)) begin
			r = WIDTH_W'(MAX_WIDTH);
		end
		return r;
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
		logic [HEIGHT_W-1:0] r;
		r = v;
		if (v < HEIGHT_W'(MIN_HEIGHT)) begin
			r = HEIGHT_W'(MIN_HEIGHT);
		end else if (v > HEIGHT_W'(MAX_HEIGHT)) begin
			r = HEIGHT_W'(MAX_HEIGHT);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = div_cnt_q != '0;
	// hold the stream while a register write is offered
	assign s_tready  = !busy && !clear_busy && !q_full && !cfg_valid;
	assign push      = s_tvalid & s_tready;
	assign mask      = mask_q;

	// column past the current width wraps to the next row before use
	assign wrap_in = {1'b0, col_q} >= w_q;
	assign col0    = wrap_in ? '0 : col_q;
	assign row0    = wrap_in ? row_q + ROW_W'(1) : row_q;
	assign r_ext   = {1'b0, row0};
	assign h_ext   = {1'b0, h_q};

	assign emit     = (row0 >= ROW_W'(2)) || ((row0 == ROW_W'(1)) && (col0 != '0));
	assign col_inc  = {1'b0, col0} + WIDTH_W'(1);
	assign col_wrap = col_inc >= w_q;

	assign first_col = out_col_q == '0;
	assign eor       = {1'b0, out_col_q} == (w_q - WIDTH_W'(1));
	assign eof       = ({1'b0, out_count_q} + (QCNT_W+1)'(1)) >= {1'b0, hw_q};
	assign oc_inc    = {1'b0, out_col_q} + WIDTH_W'(1);
	assign oc_next   = (oc_inc == w_q) ? '0 : oc_inc[COL_W-1:0];

	assign hw_full = w_q * h_q;

	// one quotient bit per cycle, remainder kept in the result column register
	assign div_idx   = div_cnt_q - DIV_CNT_W'(1);
	assign div_shift = {out_col_q, out_count_q[div_idx]};
	assign div_rem   = (div_shift >= w_q) ? COL_W'(div_shift - w_q) : div_shift[COL_W-1:0];

	always_comb begin
		push_item.col       = col0;
		push_item.pix       = s_tdata[PIX_W-1:0];
		push_item.tap0_en   = (row0 >= ROW_W'(2)) && (r_ext < h_ext + (ROW_W+1)'(2));
		push_item.tap1_en   = (row0 != '0) && (r_ext < h_ext + (ROW_W+1)'(1));
		push_item.tap2_en   = (r_ext < h_ext) && !s_tuser;
		push_item.emit      = emit;
		push_item.first_col = first_col;
		push_item.eor       = eor;
		push_item.eof       = eof;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= QCNT_W'(MAX_WIDTH * MAX_WIDTH);
		end else begin
			hw_q <= hw_full[QCNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			w_q         <= WIDTH_W'(MAX_WIDTH);
			h_q         <= HEIGHT_W'(MAX_WIDTH);
			col_q       <= '0;
			row_q       <= '0;
			out_count_q <= '0;
			out_col_q   <= '0;
			div_cnt_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_MASK_SELECT:  mask_q <= cfg_data[MASK_W-1:0];
				CFG_IMAGE_WIDTH:  w_q    <= clamp_width(cfg_data[WIDTH_W-1:0]);
				CFG_IMAGE_HEIGHT: h_q    <= clamp_height(cfg_data[HEIGHT_W-1:0]);
				default: ;
			endcase
			// rebuild the result column against the new width
			out_col_q <= '0;
			div_cnt_q <= DIV_CNT_W'(QCNT_W);
		end else if (busy) begin
			out_col_q <= div_rem;
			div_cnt_q <= div_idx;
		end else if (push) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row0 + ROW_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row0;
			end
			if (emit) begin
				if (eof) begin
					col_q       <= '0;
					row_q       <= '0;
					out_count_q <= '0;
					out_col_q   <= '0;
				end else begin
					out_count_q <= out_count_q + QCNT_W'(1);
					out_col_q   <= oc_next;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ({1'b0, out_col_q} < w_q))
		else $error("result column not below the row width");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && emit && eof) |=> (out_count_q == '0 && row_q == '0 && col_q == '0))
		else $error("frame end did not return the counters to zero");

endmodule

`default_nettype wire

>>> rtl/core/c3f_queue.sv
// ----------------------------------------------------------------------------
// c3f_queue - short item queue between front and back
// Register-based FIFO; full comes from the stored count only.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire c3f_pkg::c3f_item_t push_item,
	input  wire logic               pop,
	output c3f_pkg::c3f_item_t      head_item,
	output logic                    not_empty,
	output logic                    full
);

	import c3f_pkg::*;

	c3f_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign head_item = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == QCOUNT_W'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCOUNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCOUNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty) && !(push && full && !pop))
		else $error("queue overrun or underrun");

endmodule

`default_nettype wire

>>> rtl/core/c3f_back.sv
// ----------------------------------------------------------------------------
// c3f_back - line memory, tap window and mask arithmetic
// Reads the two rows above for each item, shifts the 3x3 window, forms
// per-row sums and the final sum into the output register. All stages
// advance together whenever the output register is free or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire c3f_pkg::c3f_item_t                 head_item,
	input  wire logic                               not_empty,
	output logic                                    pop,
	input  wire logic [c3f_pkg::MASK_W-1:0]         mask,
	output logic                                    clear_busy,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [c3f_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [12:0] filtered_value
	output logic                                    m_tuser,   // end_of_row
	output logic                                    m_tlast    // end_of_frame
);

	import c3f_pkg::*;

	logic                     adv;
	logic [CLR_W-1:0]         clr_cnt_q;

	logic                     ram_we;
	logic [COL_W-1:0]         ram_waddr;
	logic [LINE_W-1:0]        ram_wdata;
	logic [LINE_W-1:0]        ram_rdata;

	logic                     v_s1;
	c3f_item_t                item_s1;
	logic                     byp_s1;
	logic [LINE_W-1:0]        byp_data_s1;
	logic [LINE_W-1:0]        line_s1;
	logic [PIX_W-1:0]         tap [3];
	logic [LINE_W-1:0]        line_wr;

	logic [PIX_W-1:0]         window_q [3][3];
	logic                     v_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic                     eof_s2;

	logic signed [RES_W-1:0]  prod [3][3];
	logic signed [RES_W-1:0]  row_sum [3];

	logic                     v_s3;
	logic signed [RES_W-1:0]  row_s3 [3];
	logic                     eor_s3;
	logic                     eof_s3;

	logic                     m_valid_q;
	logic [RES_W-1:0]         res_q;
	logic                     eor_q;
	logic                     eof_q;

	assign clear_busy = !clr_cnt_q[CLR_W-1];
	assign adv        = !m_valid_q || m_tready;
	assign pop        = adv && not_empty && !clear_busy;

	// stage 1: line memory data back; forward a write to the same column
	assign line_s1 = byp_s1 ? byp_data_s1 : ram_rdata;
	assign tap[0]  = item_s1.tap0_en ? line_s1[LINE_W-1:PIX_W] : '0;
	assign tap[1]  = item_s1.tap1_en ? line_s1[PIX_W-1:0] : '0;
	assign tap[2]  = item_s1.tap2_en ? item_s1.pix : '0;
	assign line_wr = {line_s1[PIX_W-1:0], tap[2]};

	assign ram_we    = clear_busy || (adv && v_s1);
	assign ram_waddr = clear_busy ? clr_cnt_q[COL_W-1:0] : item_s1.col;
	assign ram_wdata = clear_busy ? '0 : line_wr;

	c3f_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk       (clk),
		.we        (ram_we),
		.waddr     (ram_waddr),
		.wdata     (ram_wdata),
		.re        (adv),
		.raddr     (head_item.col),
		.rd_data_q (ram_rdata)
	);

	// stage 2: tap products, dropping columns outside the frame
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int m = 0; m < 3; m++) begin
				if ((m == 0 && first_s2) || (m == 2 && last_s2)) begin
					prod[k][m] = '0;
				end else begin
					prod[k][m] = $signed({{(RES_W-PIX_W){1'b0}}, window_q[k][m]})
						* $signed({{(RES_W-COEF_W){KERNELS[mask][k][m][COEF_W-1]}},
							KERNELS[mask][k][m]});
				end
			end
			row_sum[k] = prod[k][0] + prod[k][1] + prod[k][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				for (int m = 0; m < 3; m++) begin
					window_q[k][m] <= '0;
				end
			end
		end else begin
			if (clear_busy) begin
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			end
			if (adv) begin
				v_s1      <= pop;
				v_s2      <= v_s1 && item_s1.emit;
				v_s3      <= v_s2;
				m_valid_q <= v_s3;
				if (v_s1) begin
					for (int k = 0; k < 3; k++) begin
						window_q[k][0] <= window_q[k][1];
						window_q[k][1] <= window_q[k][2];
						window_q[k][2] <= tap[k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1     <= head_item;
			byp_s1      <= v_s1 && (head_item.col == item_s1.col);
			byp_data_s1 <= line_wr;
			first_s2    <= item_s1.first_col;
			last_s2     <= item_s1.eor;
			eof_s2      <= item_s1.eof;
			for (int k = 0; k < 3; k++) begin
				row_s3[k] <= row_sum[k];
			end
			eor_s3      <= last_s2;
			eof_s3      <= eof_s2;
			res_q       <= row_s3[0] + row_s3[1] + row_s3[2];
			eor_q       <= eor_s3;
			eof_q       <= eof_s3;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W-RES_W){1'b0}}, res_q};
	assign m_tuser  = eor_q;
	assign m_tlast  = eof_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> (!v_s1 && !pop))
		else $error("item in flight while the line memory is cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !m_tvalid)
		else $error("result shown during the clearing pass");

endmodule

`default_nettype wire
